### hdl/pihv_pkg.sv
// Shared definitions for the program image header validator.
// Holds status codes, register indexes, size constants and the segment table types.
// No dependencies.
package pihv_pkg;

    localparam int unsigned DEF_MAX_SEGMENTS   = 16;
    localparam int unsigned DEF_MAX_FILE_BYTES = 65536;

    localparam logic [31:0] HEADER_BYTES     = 32'd28;
    localparam logic [31:0] DESCRIPTOR_BYTES = 32'd32;

    typedef logic [2:0] t_status;

    localparam t_status ST_OK          = 3'd0;
    localparam t_status ST_BAD_MAGIC   = 3'd1;
    localparam t_status ST_BAD_VERSION = 3'd2;
    localparam t_status ST_BAD_ARCH    = 3'd3;
    localparam t_status ST_BAD_HEADER  = 3'd4;
    localparam t_status ST_UNSUPPORTED = 3'd5;
    localparam t_status ST_TOO_LARGE   = 3'd6;

    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_VERSION = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ARCH  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_TYPE      = 8'd3;

    // One stored segment: its memory range in a form that needs no adder during the walk.
    typedef struct packed {
        logic [31:0] seg_lo;
        logic [31:0] seg_hi;
        logic        wrap;
        logic        nonzero;
        t_status     err;
    } t_seg_entry;

    typedef struct packed {
        logic    done;
        t_status status;
    } t_walk_rsp;

endpackage

### hdl/pihv_walk.sv
// Segment table and the sequencer that walks it after the last descriptor.
// One compare unit checks one stored pair per step. Depends on pihv_pkg.
module pihv_walk import pihv_pkg::*; #(
    parameter int unsigned MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_wr_en,
    input  logic [((MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1)-1:0] i_wr_addr,
    input  t_seg_entry                              i_wr_entry,
    input  logic                                    i_start,
    input  logic [$clog2(MAX_SEGMENTS + 1)-1:0]     i_count,
    input  logic                                    i_ack,
    output t_walk_rsp                               o_rsp
);

    localparam int unsigned AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);

    localparam logic [2:0] W_IDLE  = 3'd0;
    localparam logic [2:0] W_RD_I  = 3'd1;
    localparam logic [2:0] W_CHK_I = 3'd2;
    localparam logic [2:0] W_RD_J  = 3'd3;
    localparam logic [2:0] W_CMP   = 3'd4;
    localparam logic [2:0] W_DONE  = 3'd5;

    t_seg_entry r_mem [MAX_SEGMENTS];
    t_seg_entry r_rd;
    t_seg_entry r_a, n_a;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_j, n_j;
    logic [CW-1:0] r_n, n_n;
    t_status       r_status, n_status;

    logic [AW-1:0] rd_addr;
    logic [CW-1:0] i_plus;
    logic [CW-1:0] j_plus;
    logic          clash;

    assign rd_addr = (r_state == W_RD_I) ? r_i : r_j;
    assign i_plus  = CW'(r_i) + CW'(1);
    assign j_plus  = CW'(r_j) + CW'(1);

    // A wrapped range clashes with every nonempty range; otherwise the usual interval test.
    assign clash = r_a.nonzero && r_rd.nonzero &&
                   (r_a.wrap || r_rd.wrap ||
                    ((r_a.seg_lo < r_rd.seg_hi) && (r_rd.seg_lo < r_a.seg_hi)));

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_comb begin
        n_state  = r_state;
        n_i      = r_i;
        n_j      = r_j;
        n_n      = r_n;
        n_a      = r_a;
        n_status = r_status;
        unique case (r_state)
            W_IDLE: begin
                if (i_start) begin
                    n_n     = i_count;
                    n_i     = '0;
                    n_state = W_RD_I;
                end
            end
            W_RD_I: begin
                n_state = W_CHK_I;
            end
            W_CHK_I: begin
                n_a = r_rd;
                if (r_rd.err != ST_OK) begin
                    n_status = r_rd.err;
                    n_state  = W_DONE;
                end else if (i_plus >= r_n) begin
                    n_status = ST_OK;
                    n_state  = W_DONE;
                end else begin
                    n_j     = i_plus[AW-1:0];
                    n_state = W_RD_J;
                end
            end
            W_RD_J: begin
                n_state = W_CMP;
            end
            W_CMP: begin
                if (clash) begin
                    n_status = ST_BAD_HEADER;
                    n_state  = W_DONE;
                end else if (j_plus < r_n) begin
                    n_j     = j_plus[AW-1:0];
                    n_state = W_RD_J;
                end else begin
                    n_i     = i_plus[AW-1:0];
                    n_state = W_RD_I;
                end
            end
            W_DONE: begin
                if (i_ack) begin
                    n_state = W_IDLE;
                end
            end
            default: begin
                n_state = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= W_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_i      <= n_i;
        r_j      <= n_j;
        r_n      <= n_n;
        r_a      <= n_a;
        r_status <= n_status;
    end

    assign o_rsp.done   = (r_state == W_DONE);
    assign o_rsp.status = r_status;

endmodule

### hdl/program_image_header_validator.sv
// Top level of the program image header validator.
// Holds the configuration registers, header and descriptor checks and the result register.
// Depends on pihv_pkg and pihv_walk.
//
// Items arrive on the input channel (i_in_valid, o_in_stall); a header item has i_mode
// low, a segment descriptor has it high. Results leave on the output channel
// (o_out_valid, i_out_stall) as a 3-bit status. Configuration registers are written
// through i_cfg_valid / o_cfg_ready with a register index and 32-bit data; the port is
// always ready and writes to unknown indexes are dropped.
// Every accepted item is checked in the S_CHECK state after its transfer. A failing header
// puts its status in the output register once the output slot is free. A passing header,
// or a descriptor that is not the last one, gives no result and the block then returns to
// idle, ready again. The last descriptor starts the table walk: each stored entry is read
// once, and each later pair takes a read step and a compare step through the single
// compare unit and its one memory read port.
// The input side is stalled while an item is in work. A waiting result does not stall
// the input; only a second result stalls the block until the first is taken.
// Reset clears the configuration registers to their defaults, drops any collection in
// progress and empties the output register; the segment table itself is not cleared.
module program_image_header_validator import pihv_pkg::*; #(
    parameter int unsigned MAX_SEGMENTS   = DEF_MAX_SEGMENTS,
    parameter int unsigned MAX_FILE_BYTES = DEF_MAX_FILE_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_mode,
    input  logic [31:0]          i_magic,
    input  logic [31:0]          i_arch,
    input  logic [31:0]          i_seg_total,
    input  logic [31:0]          i_id_word,
    input  logic [31:0]          i_offset,
    input  logic [31:0]          i_byte_count,
    input  logic [31:0]          i_must_be_zero,
    input  logic [31:0]          i_vaddr,
    input  logic [31:0]          i_memsz,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [2:0]           o_status,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int unsigned AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [31:0] MAX_BYTES_W = 32'(MAX_FILE_BYTES);
    localparam logic [31:0] MAX_SEGS_W  = 32'(MAX_SEGMENTS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;

    logic [1:0] r_state, n_state;

    logic [31:0] r_cfg_magic, r_cfg_version, r_cfg_arch, r_cfg_load;

    logic        r_mode;
    logic [31:0] r_magic, r_arch, r_seg_total, r_id_word, r_offset;
    logic [31:0] r_byte_count, r_must_be_zero, r_vaddr, r_memsz;

    logic          r_collect, n_collect;
    logic [31:0]   r_file_len, n_file_len;
    logic [CW-1:0] r_expected, n_expected;
    logic [CW-1:0] r_received, n_received;

    logic    r_out_valid, n_out_valid;
    t_status r_status, n_status;

    logic       in_xfer;
    logic       slot_free;
    t_status    hdr_status;
    t_status    seg_status;
    logic [31:0] table_bytes;
    logic       table_fits;
    logic       data_fits;
    logic [32:0] seg_sum;
    logic [CW-1:0] recv_plus;

    t_seg_entry wr_entry;
    logic       wr_en;
    logic       walk_start;
    logic       walk_ack;
    t_walk_rsp  walk_rsp;

    assign in_xfer     = i_in_valid && !o_in_stall;
    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_magic   <= '0;
            r_cfg_version <= '0;
            r_cfg_arch    <= '0;
            r_cfg_load    <= 32'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAGIC_WORD:     r_cfg_magic   <= i_cfg_data;
                CFG_FORMAT_VERSION: r_cfg_version <= i_cfg_data;
                CFG_EXPECTED_ARCH:  r_cfg_arch    <= i_cfg_data;
                CFG_LOAD_TYPE:      r_cfg_load    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_mode         <= i_mode;
            r_magic        <= i_magic;
            r_arch         <= i_arch;
            r_seg_total    <= i_seg_total;
            r_id_word      <= i_id_word;
            r_offset       <= i_offset;
            r_byte_count   <= i_byte_count;
            r_must_be_zero <= i_must_be_zero;
            r_vaddr        <= i_vaddr;
            r_memsz        <= i_memsz;
        end
    end

    // Header checks in priority order; the table size only matters once the count is sane.
    assign table_bytes = 32'(r_seg_total * DESCRIPTOR_BYTES);
    assign table_fits  = (r_offset <= r_byte_count) &&
                         (table_bytes <= (r_byte_count - r_offset));

    always_comb begin
        if (r_byte_count > MAX_BYTES_W) begin
            hdr_status = ST_TOO_LARGE;
        end else if ((r_byte_count < HEADER_BYTES) || (r_magic != r_cfg_magic)) begin
            hdr_status = ST_BAD_MAGIC;
        end else if (r_id_word != r_cfg_version) begin
            hdr_status = ST_BAD_VERSION;
        end else if (r_arch != r_cfg_arch) begin
            hdr_status = ST_BAD_ARCH;
        end else if ((r_must_be_zero != '0) || (r_seg_total == '0) ||
                     (r_seg_total > MAX_SEGS_W)) begin
            hdr_status = ST_BAD_HEADER;
        end else if (!table_fits) begin
            hdr_status = ST_BAD_HEADER;
        end else begin
            hdr_status = ST_OK;
        end
    end

    assign data_fits = (r_offset <= r_file_len) &&
                       (r_byte_count <= (r_file_len - r_offset));

    always_comb begin
        if (r_id_word != r_cfg_load) begin
            seg_status = ST_UNSUPPORTED;
        end else if (r_memsz < r_byte_count) begin
            seg_status = ST_BAD_HEADER;
        end else if (!data_fits) begin
            seg_status = ST_BAD_HEADER;
        end else if (r_must_be_zero != '0) begin
            seg_status = ST_BAD_HEADER;
        end else begin
            seg_status = ST_OK;
        end
    end

    // The end address and its carry are kept so the walk compares without adding.
    assign seg_sum          = {1'b0, r_vaddr} + {1'b0, r_memsz};
    assign wr_entry.seg_lo  = r_vaddr;
    assign wr_entry.seg_hi  = seg_sum[31:0];
    assign wr_entry.wrap    = seg_sum[32];
    assign wr_entry.nonzero = (r_memsz != '0);
    assign wr_entry.err     = seg_status;

    assign recv_plus  = r_received + CW'(1);
    assign wr_en      = (r_state == S_CHECK) && r_mode && r_collect &&
                        (r_received < CW'(MAX_SEGMENTS));
    assign walk_start = wr_en && (recv_plus >= r_expected);
    assign walk_ack   = (r_state == S_WALK) && walk_rsp.done && slot_free;

    always_comb begin
        n_state     = r_state;
        n_collect   = r_collect;
        n_file_len  = r_file_len;
        n_expected  = r_expected;
        n_received  = r_received;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!r_mode) begin
                    if (hdr_status != ST_OK) begin
                        if (slot_free) begin
                            n_out_valid = 1'b1;
                            n_status    = hdr_status;
                            n_collect   = 1'b0;
                            n_state     = S_IDLE;
                        end
                    end else begin
                        n_collect  = 1'b1;
                        n_file_len = r_byte_count;
                        n_expected = r_seg_total[CW-1:0];
                        n_received = '0;
                        n_state    = S_IDLE;
                    end
                end else if (walk_start) begin
                    n_received = recv_plus;
                    n_state    = S_WALK;
                end else begin
                    if (wr_en) begin
                        n_received = recv_plus;
                    end
                    n_state = S_IDLE;
                end
            end
            S_WALK: begin
                if (walk_ack) begin
                    n_out_valid = 1'b1;
                    n_status    = walk_rsp.status;
                    n_collect   = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_collect   <= 1'b0;
            r_file_len  <= '0;
            r_expected  <= '0;
            r_received  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_collect   <= n_collect;
            r_file_len  <= n_file_len;
            r_expected  <= n_expected;
            r_received  <= n_received;
            r_out_valid <= n_out_valid;
        end
        r_status <= n_status;
    end

    pihv_walk #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_received[AW-1:0]),
        .i_wr_entry (wr_entry),
        .i_start    (walk_start),
        .i_count    (r_expected),
        .i_ack      (walk_ack),
        .o_rsp      (walk_rsp)
    );

endmodule

### test/testbench.sv
// Self-checking testbench for program_image_header_validator: header and segment table checks.
// A built-in status predictor checks every result, under several register settings and stalls.
// Depends on pihv_pkg and the validator RTL.
module testbench;
    import pihv_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 32;

    typedef struct {
        logic        mode;
        logic [31:0] magic;
        logic [31:0] arch;
        logic [31:0] seg_total;
        logic [31:0] id_word;
        logic [31:0] offset;
        logic [31:0] byte_count;
        logic [31:0] must_be_zero;
        logic [31:0] vaddr;
        logic [31:0] memsz;
    } t_image_item;

    typedef enum {HF_MAGIC, HF_VERSION, HF_ARCH, HF_FLAGS, HF_COUNT, HF_SIZE, HF_TABLE,
                  HF_GARBLED} t_header_flaw;
    typedef enum {SF_TYPE, SF_SHORT_MEM, SF_OUTSIDE, SF_RESERVED, SF_OVERLAP, SF_WRAP,
                  SF_GARBLED} t_segment_flaw;
    typedef enum {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_PATTERN} t_flow_style;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_stall;
    logic                 i_mode         = 1'b0;
    logic [31:0]          i_magic        = '0;
    logic [31:0]          i_arch         = '0;
    logic [31:0]          i_seg_total    = '0;
    logic [31:0]          i_id_word      = '0;
    logic [31:0]          i_offset       = '0;
    logic [31:0]          i_byte_count   = '0;
    logic [31:0]          i_must_be_zero = '0;
    logic [31:0]          i_vaddr        = '0;
    logic [31:0]          i_memsz        = '0;
    logic                 o_out_valid;
    logic                 i_out_stall    = 1'b0;
    logic [2:0]           o_status;
    logic                 i_cfg_valid    = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [31:0]          i_cfg_data     = '0;

    program_image_header_validator i_dut (.*);

    // Shadow registers and predictor state.
    logic [31:0] cfg_magic     = 32'd0;
    logic [31:0] cfg_version   = 32'd0;
    logic [31:0] cfg_arch      = 32'd0;
    logic [31:0] cfg_load_type = 32'd1;
    bit          collecting    = 1'b0;
    logic [31:0] file_bytes    = '0;
    int unsigned seg_count     = 0;
    int unsigned seg_fill      = 0;
    logic [31:0] seg_base  [DEF_MAX_SEGMENTS];
    logic [31:0] seg_size  [DEF_MAX_SEGMENTS];
    t_status     seg_fault [DEF_MAX_SEGMENTS];

    t_status     status_due[$];
    int unsigned items_judged    = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches      = 0;
    int unsigned cycles          = 0;

    int unsigned burst_left   = 0;
    bit          steady       = 1'b0;
    int unsigned hold_request = 0;
    int unsigned hold_left    = 0;
    int unsigned style_left   = 0;
    t_flow_style flow_style   = FLOW_FREE;
    logic [31:0] flow_pattern = '0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles,
                     status_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycles, msg);
        mismatches++;
    endtask

    function automatic bit fits_file(input logic [31:0] at, input logic [31:0] len,
                                     input logic [31:0] total);
        return (at <= total) && (len <= total - at);
    endfunction

    // Works out the status, if any, that one accepted item causes.
    task automatic judge_item(input t_image_item it);
        t_status     verdict;
        t_status     fault;
        logic [31:0] a_end;
        logic [31:0] b_end;
        int unsigned i;
        int unsigned j;
        if (!it.mode) begin
            items_judged++;
            if (it.byte_count > DEF_MAX_FILE_BYTES)
                verdict = ST_TOO_LARGE;
            else if (it.byte_count < HEADER_BYTES || it.magic != cfg_magic)
                verdict = ST_BAD_MAGIC;
            else if (it.id_word != cfg_version)
                verdict = ST_BAD_VERSION;
            else if (it.arch != cfg_arch)
                verdict = ST_BAD_ARCH;
            else if (it.must_be_zero != 0 || it.seg_total == 0 ||
                     it.seg_total > DEF_MAX_SEGMENTS)
                verdict = ST_BAD_HEADER;
            else if (!fits_file(it.offset, it.seg_total * DESCRIPTOR_BYTES, it.byte_count))
                verdict = ST_BAD_HEADER;
            else
                verdict = ST_OK;
            if (verdict != ST_OK) begin
                collecting = 1'b0;
                status_due.push_back(verdict);
            end else begin
                // A new header always drops a partial collection.
                collecting = 1'b1;
                file_bytes = it.byte_count;
                seg_count  = it.seg_total;
                seg_fill   = 0;
            end
        end else if (collecting && seg_fill < DEF_MAX_SEGMENTS) begin
            items_judged++;
            if (it.id_word != cfg_load_type)
                fault = ST_UNSUPPORTED;
            else if (it.memsz < it.byte_count)
                fault = ST_BAD_HEADER;
            else if (!fits_file(it.offset, it.byte_count, file_bytes))
                fault = ST_BAD_HEADER;
            else if (it.must_be_zero != 0)
                fault = ST_BAD_HEADER;
            else
                fault = ST_OK;
            seg_base[seg_fill]  = it.vaddr;
            seg_size[seg_fill]  = it.memsz;
            seg_fault[seg_fill] = fault;
            seg_fill++;
            if (seg_fill == seg_count) begin
                verdict = ST_OK;
                for (i = 0; i < seg_count && verdict == ST_OK; i++) begin
                    if (seg_fault[i] != ST_OK) begin
                        verdict = seg_fault[i];
                    end else begin
                        for (j = i + 1; j < seg_count && verdict == ST_OK; j++) begin
                            // Empty segments never clash; a range that wraps always does.
                            if (seg_size[i] != 0 && seg_size[j] != 0) begin
                                a_end = seg_base[i] + seg_size[i];
                                b_end = seg_base[j] + seg_size[j];
                                if (a_end < seg_base[i] || b_end < seg_base[j] ||
                                    (seg_base[i] < b_end && seg_base[j] < a_end))
                                    verdict = ST_BAD_HEADER;
                            end
                        end
                    end
                end
                collecting = 1'b0;
                status_due.push_back(verdict);
            end
        end
    endtask

    // The sender works in bursts; between bursts a gap may drop valid before the next transfer.
    task automatic send_item(input t_image_item it);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if (!steady && $urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= it.mode;
        i_magic        <= it.magic;
        i_arch         <= it.arch;
        i_seg_total    <= it.seg_total;
        i_id_word      <= it.id_word;
        i_offset       <= it.offset;
        i_byte_count   <= it.byte_count;
        i_must_be_zero <= it.must_be_zero;
        i_vaddr        <= it.vaddr;
        i_memsz        <= it.memsz;
        do @(posedge i_clk); while (o_in_stall);
        judge_item(it);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MAGIC_WORD:     cfg_magic     = data;
            CFG_FORMAT_VERSION: cfg_version   = data;
            CFG_EXPECTED_ARCH:  cfg_arch      = data;
            CFG_LOAD_TYPE:      cfg_load_type = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (status_due.size() != 0) @(posedge i_clk);
        // Items that give no status may still be in work.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_image_item random_item();
        t_image_item it;
        it.mode         = 1'($urandom_range(0, 1));
        it.magic        = $urandom;
        it.arch         = $urandom;
        it.seg_total    = $urandom;
        it.id_word      = $urandom;
        it.offset       = $urandom;
        it.byte_count   = $urandom;
        it.must_be_zero = $urandom;
        it.vaddr        = $urandom;
        it.memsz        = $urandom;
        return it;
    endfunction

    function automatic t_image_item header_for(input int unsigned n);
        t_image_item it;
        it              = random_item();
        it.mode         = 1'b0;
        it.magic        = cfg_magic;
        it.arch         = cfg_arch;
        it.id_word      = cfg_version;
        it.must_be_zero = '0;
        it.seg_total    = n;
        it.byte_count   = $urandom_range(n * DESCRIPTOR_BYTES, ($urandom_range(0, 3) == 0) ?
                                         DEF_MAX_FILE_BYTES : n * DESCRIPTOR_BYTES + 512);
        it.offset       = $urandom_range(0, it.byte_count - n * DESCRIPTOR_BYTES);
        return it;
    endfunction

    function automatic t_image_item segment_for(input logic [31:0] vaddr,
                                                input logic [31:0] memsz,
                                                input logic [31:0] flen);
        t_image_item it;
        logic [31:0] lim;
        it              = random_item();
        it.mode         = 1'b1;
        it.id_word      = cfg_load_type;
        it.vaddr        = vaddr;
        it.memsz        = memsz;
        it.must_be_zero = '0;
        lim             = (memsz < flen) ? memsz : flen;
        it.byte_count   = $urandom_range(0, lim);
        it.offset       = $urandom_range(0, flen - it.byte_count);
        return it;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (status_due.size() == 0) begin
                report_mismatch($sformatf("status %0d with nothing pending", o_status));
            end else begin
                if (o_status !== status_due[0])
                    report_mismatch($sformatf("status %0d, expected %0d", o_status,
                                              status_due[0]));
                void'(status_due.pop_front());
                results_checked++;
            end
        end
    end

    // The receiver picks a new stall style whenever the current one runs out; a hold-off overrides it.
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            if (style_left == 0) begin
                flow_style   = t_flow_style'($urandom_range(0, 3));
                style_left   = $urandom_range(20, 300);
                flow_pattern = $urandom;
            end
            style_left--;
            case (flow_style)
                FLOW_FREE:  i_out_stall <= 1'b0;
                FLOW_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                FLOW_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: begin
                    i_out_stall  <= flow_pattern[0];
                    flow_pattern = {flow_pattern[0], flow_pattern[31:1]};
                end
            endcase
        end
    end

    task automatic test_header_checks();
        t_image_item it;
        it = header_for(1);
        it.byte_count = DEF_MAX_FILE_BYTES + 1;
        send_item(it);
        it.byte_count = 32'hFFFF_FFFF;
        send_item(it);
        it = header_for(1);
        it.byte_count = HEADER_BYTES - 1;
        send_item(it);
        it = header_for(1);
        it.magic = ~cfg_magic;
        send_item(it);
        it = header_for(1);
        it.id_word = ~cfg_version;
        send_item(it);
        it = header_for(1);
        it.arch = ~cfg_arch;
        send_item(it);
        it = header_for(1);
        it.must_be_zero = 32'h8000_0000;
        send_item(it);
        it = header_for(1);
        it.seg_total = 0;
        send_item(it);
        it = header_for(1);
        it.seg_total = DEF_MAX_SEGMENTS + 1;
        send_item(it);
        // The segment table runs one byte past the end of the file.
        it = header_for(2);
        it.offset = it.byte_count - 2 * DESCRIPTOR_BYTES + 1;
        send_item(it);
        // A descriptor while idle is dropped without a status.
        send_item(segment_for(32'h1000, 32'h10, 32'd64));
        wait_idle();
    endtask

    task automatic test_segment_table();
        t_image_item it;
        logic [31:0] flen;
        // Largest file, table flush with its end, an empty segment at a used address.
        it = header_for(2);
        it.byte_count = DEF_MAX_FILE_BYTES;
        it.offset     = DEF_MAX_FILE_BYTES - 2 * DESCRIPTOR_BYTES;
        flen = it.byte_count;
        send_item(it);
        send_item(segment_for(32'h1000, 32'h0, flen));
        it = segment_for(32'h1000, 32'h100, flen);
        it.byte_count = 32'h100;
        it.offset     = flen - 32'h100;
        send_item(it);
        // A new header in the middle of a collection starts over.
        it = header_for(2);
        send_item(it);
        send_item(segment_for(32'h2000, 32'h40, it.byte_count));
        it = header_for(1);
        send_item(it);
        send_item(segment_for(32'h2000, 32'h40, it.byte_count));
        // A range that wraps past the top of memory clashes with anything nonempty.
        it = header_for(2);
        flen = it.byte_count;
        send_item(it);
        send_item(segment_for(32'hFFFF_FF00, 32'h100, flen));
        send_item(segment_for(32'h0, 32'h10, flen));
        it = header_for(1);
        send_item(it);
        it = segment_for(32'h3000, 32'h20, it.byte_count);
        it.id_word = ~cfg_load_type;
        send_item(it);
        // The first segment's overlap with the third is found before the second's own error.
        it = header_for(3);
        flen = it.byte_count;
        send_item(it);
        send_item(segment_for(32'h4000, 32'h100, flen));
        it = segment_for(32'h5000, 32'h100, flen);
        it.id_word = ~cfg_load_type;
        send_item(it);
        send_item(segment_for(32'h40F0, 32'h20, flen));
        wait_idle();
    endtask

    task automatic test_random_traffic(input logic [31:0] magic, input logic [31:0] version,
                                       input logic [31:0] arch, input logic [31:0] load,
                                       input int unsigned target);
        t_image_item   it;
        t_header_flaw  hflaw;
        t_segment_flaw sflaw;
        int unsigned   goal;
        int unsigned   pick;
        int unsigned   n;
        int unsigned   k;
        int unsigned   s;
        logic [31:0]   stride;
        logic [31:0]   base;
        logic [31:0]   flen;
        logic [31:0]   memsz;
        logic [31:0]   prev_vaddr;
        write_reg(CFG_MAGIC_WORD, magic);
        write_reg(CFG_FORMAT_VERSION, version);
        write_reg(CFG_EXPECTED_ARCH, arch);
        write_reg(CFG_LOAD_TYPE, load);
        goal = items_judged + target;
        while (items_judged < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                it = random_item();
                if (pick < 4)
                    it.mode = 1'b1;
                send_item(it);
            end else begin
                pick = $urandom_range(0, 19);
                n = (pick == 0) ? DEF_MAX_SEGMENTS :
                    (pick < 4) ? $urandom_range(1, DEF_MAX_SEGMENTS) : $urandom_range(1, 4);
                it = header_for(n);
                if ($urandom_range(0, 9) == 0) begin
                    hflaw = t_header_flaw'($urandom_range(0, HF_GARBLED));
                    case (hflaw)
                        HF_MAGIC:   it.magic ^= 32'h1 << $urandom_range(0, 31);
                        HF_VERSION: it.id_word ^= 32'h1 << $urandom_range(0, 31);
                        HF_ARCH:    it.arch ^= 32'h1 << $urandom_range(0, 31);
                        HF_FLAGS:   it.must_be_zero = $urandom | (32'h1 << $urandom_range(0, 31));
                        HF_COUNT:   it.seg_total = $urandom_range(0, 1) ? 32'd0 :
                                        $urandom_range(DEF_MAX_SEGMENTS + 1, 32'hFFFF_FFFF);
                        HF_SIZE:    it.byte_count = $urandom_range(0, 1) ?
                                        $urandom_range(0, HEADER_BYTES - 1) :
                                        $urandom_range(DEF_MAX_FILE_BYTES + 1, 32'hFFFF_FFFF);
                        HF_TABLE:   it.offset = it.byte_count - n * DESCRIPTOR_BYTES +
                                        $urandom_range(1, 64);
                        default: begin
                            it = random_item();
                            it.mode = 1'b0;
                        end
                    endcase
                end
                flen = it.byte_count;
                send_item(it);
                // Now and then the table is cut short and the next header drops it.
                k = ($urandom_range(0, 19) == 0) ? $urandom_range(0, n - 1) : n;
                base = $urandom;
                stride = $urandom_range(1, 32'h0100_0000);
                prev_vaddr = base;
                for (s = 0; s < k; s++) begin
                    memsz = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, stride);
                    it = segment_for(base + s * stride, memsz, flen);
                    if ($urandom_range(0, 19) == 0) begin
                        sflaw = t_segment_flaw'($urandom_range(0, SF_GARBLED));
                        case (sflaw)
                            SF_TYPE:      it.id_word = $urandom;
                            SF_SHORT_MEM: begin
                                if (it.byte_count == 0)
                                    it.byte_count = 1;
                                it.memsz = it.byte_count - 1;
                            end
                            SF_OUTSIDE:   it.offset = flen - it.byte_count + $urandom_range(1, 256);
                            SF_RESERVED:  it.must_be_zero = $urandom |
                                              (32'h1 << $urandom_range(0, 31));
                            SF_OVERLAP: begin
                                it.vaddr = prev_vaddr + $urandom_range(0, 15);
                                it.memsz = it.byte_count + $urandom_range(1, 4096);
                            end
                            SF_WRAP: begin
                                it.vaddr = 32'hFFFF_FFFF - $urandom_range(0, 255);
                                it.memsz = it.byte_count + 32'd256 + $urandom_range(0, 4096);
                            end
                            default: begin
                                it = random_item();
                                it.mode = 1'b1;
                            end
                        endcase
                    end
                    send_item(it);
                    prev_vaddr = it.vaddr;
                end
            end
        end
        wait_idle();
    endtask

    // The receiver holds off for a long stretch while failing headers keep coming, so the
    // output register fills and the block stalls its input.
    task automatic test_backpressure();
        t_image_item it;
        hold_request = 600;
        steady = 1'b1;
        repeat (24) begin
            it = header_for(1);
            it.byte_count = DEF_MAX_FILE_BYTES + 1 + $urandom_range(0, 1000);
            send_item(it);
        end
        steady = 1'b0;
        wait_idle();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_header_checks();
        test_segment_table();
        test_random_traffic($urandom, $urandom, $urandom, $urandom_range(0, 15), 300);
        test_backpressure();
        test_random_traffic(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 200);
        test_random_traffic(32'h0, 32'h0, 32'h0, 32'h0, 200);
        test_random_traffic($urandom, $urandom, $urandom, $urandom, 300);
        $display("Judged %0d header and descriptor items and checked %0d statuses in %0d cycles.",
                 items_judged, results_checked, cycles);
        $display("Run covered header rejects, table walks, four register settings and a long hold.");
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### program_image_header_validator.f
hdl/pihv_pkg.sv
hdl/pihv_walk.sv
hdl/program_image_header_validator.sv
test/testbench.sv
